[hdl/apsp_pkg.sv]
// shared types and constants for the all-pairs shortest path unit
`default_nettype none
package apsp_pkg;

    localparam int DIST_BITS    = 21;
    localparam int VERTEX_BITS  = 5;
    localparam int WEIGHT_FIELD = 16;
    localparam int COUNT_BITS   = 6;
    localparam int RESULT_LIMIT = 32;
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 6'd32;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_RUN   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW_RD,
        S_ROW_CHK,
        S_REL_RD,
        S_REL_WR,
        S_Q_RD,
        S_Q_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]              operation;
        logic [VERTEX_BITS-1:0]  src_vertex;
        logic [VERTEX_BITS-1:0]  dst_vertex;
        logic [WEIGHT_FIELD-1:0] edge_weight;
        logic                    no_edge;
    } cmd_t;

    typedef struct packed {
        logic [VERTEX_BITS-1:0] path_vertex;
        logic [DIST_BITS-1:0]   path_distance;
        logic                   found;
        logic                   last;
    } result_t;

endpackage
`default_nettype wire

[hdl/all_pairs_shortest_path_unit.sv]
// all-pairs shortest path unit: table memory, closure sequencer and path walker
//
// usage: one command beat is taken at a clock edge where start is high and
// busy is low. a load beat writes one table entry. a run beat relaxes every
// (k, i, j) triple over the first vertex_count vertices whose (i, k) entry
// is valid: each row (i, k) is read, then checked, and each relaxation is
// read, then compared and written back. a query beat walks next hops, one
// result beat per hop (each read, then emitted), up to 32 beats, the final
// one marked by last. an unreachable pair gives one beat with found low.
// results appear on result for exactly one cycle, marked by result_valid;
// the receiver cannot stall. the user writes vertex_count through
// cfg_we/cfg_data only while busy is low; the block does not enforce this.
// reset clears the sequencer and sets vertex_count to 32; the tables are
// undefined until loaded, and the user loads all entries before a run; the
// block does not enforce that either.
`default_nettype none
module all_pairs_shortest_path_unit
    import apsp_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS  = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire cmd_t                  cmd,
    output result_t                    result,
    output logic                       result_valid,
    input  wire logic                  cfg_we,
    input  wire logic [COUNT_BITS-1:0] cfg_data
);

    localparam int VB    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = 8;
    localparam int WB    = (WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS;
    localparam int WU    = (WEIGHT_BITS < WEIGHT_FIELD) ? WEIGHT_BITS : WEIGHT_FIELD;

    typedef struct packed {
        logic                 valid;
        logic [VB-1:0]        hop;
        logic [DIST_BITS-1:0] length;
    } entry_t;

    function automatic logic [AW-1:0] cell_addr(input logic [VB-1:0] r, input logic [VB-1:0] c);
        logic [AW+VB-1:0] full;
        begin
            full = (AW+VB)'(r) * (AW+VB)'(MAX_VERTICES) + (AW+VB)'(c);
            return full[AW-1:0];
        end
    endfunction

    // table memory, one write port and two registered read ports
    entry_t mem [DEPTH];
    logic [AW-1:0] a_addr, b_addr, w_addr;
    entry_t        a_q, b_q, w_data;
    logic          w_en;

    always_ff @(posedge clk)
    begin
        if (w_en)
        begin
            mem[w_addr] <= w_data;
        end
        a_q <= mem[a_addr];
        b_q <= mem[b_addr];
    end

    // control and datapath registers
    state_t                state_reg, state_next;
    logic [COUNT_BITS-1:0] vcount_reg, vcount_next;
    logic [VB-1:0]         last_reg, last_next;
    logic [VB-1:0]         k_reg, k_next, i_reg, i_next, j_reg, j_next;
    logic [VB-1:0]         ik_hop_reg, ik_hop_next;
    logic [DIST_BITS-1:0]  ik_dist_reg, ik_dist_next;
    logic [VB-1:0]         qu_reg, qu_next, qv_reg, qv_next;
    logic [VERTEX_BITS-1:0] cnt_reg, cnt_next;
    logic [DIST_BITS-1:0]  qdist_reg, qdist_next;
    logic                  first_reg, first_next;
    result_t               result_reg, result_next;
    logic                  rvalid_reg, rvalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            vcount_reg <= COUNT_RESET;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            vcount_reg <= vcount_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg    <= last_next;
        k_reg       <= k_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        ik_hop_reg  <= ik_hop_next;
        ik_dist_reg <= ik_dist_next;
        qu_reg      <= qu_next;
        qv_reg      <= qv_next;
        cnt_reg     <= cnt_next;
        qdist_reg   <= qdist_next;
        first_reg   <= first_next;
        result_reg  <= result_next;
    end

    // command decode helpers
    logic [CW-1:0]          src_w, dst_w, n_sat;
    logic                   src_ok, dst_ok;
    logic [VB+VERTEX_BITS-1:0] src_x, dst_x;
    logic [VB-1:0]          src_v, dst_v;
    logic [WB-1:0]          wt;
    logic [DIST_BITS-1:0]   wt_sat;
    logic [DIST_BITS:0]     sum_full;
    logic [DIST_BITS-1:0]   sum_sat;
    logic [VB+VERTEX_BITS-1:0] pv_x;
    logic [CW-1:0]          hop_w;
    logic                   q_done;

    always_comb
    begin
        src_w  = CW'(cmd.src_vertex);
        dst_w  = CW'(cmd.dst_vertex);
        src_ok = src_w < CW'(MAX_VERTICES);
        dst_ok = dst_w < CW'(MAX_VERTICES);
        src_x  = (VB+VERTEX_BITS)'(cmd.src_vertex);
        dst_x  = (VB+VERTEX_BITS)'(cmd.dst_vertex);
        src_v  = src_x[VB-1:0];
        dst_v  = dst_x[VB-1:0];
        wt     = WB'(cmd.edge_weight[WU-1:0]);
        wt_sat = (wt > WB'(DIST_MAX)) ? DIST_MAX : wt[DIST_BITS-1:0];
        n_sat  = (CW'(vcount_reg) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                      : CW'(vcount_reg);
        sum_full = {1'b0, ik_dist_reg} + {1'b0, a_q.length};
        sum_sat  = sum_full[DIST_BITS] ? DIST_MAX : sum_full[DIST_BITS-1:0];
        pv_x     = (VB+VERTEX_BITS)'(qu_reg);
        hop_w    = CW'(a_q.hop);
        q_done   = (qu_reg == qv_reg) || (cnt_reg == VERTEX_BITS'(RESULT_LIMIT - 1)) ||
                   !a_q.valid || (hop_w >= CW'(MAX_VERTICES));
    end

    // sequencer: next state, memory ports and result beat
    always_comb
    begin
        state_next   = state_reg;
        vcount_next  = vcount_reg;
        last_next    = last_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        ik_hop_next  = ik_hop_reg;
        ik_dist_next = ik_dist_reg;
        qu_next      = qu_reg;
        qv_next      = qv_reg;
        cnt_next     = cnt_reg;
        qdist_next   = qdist_reg;
        first_next   = first_reg;
        result_next  = result_reg;
        rvalid_next  = 1'b0;
        a_addr       = cell_addr(i_reg, k_reg);
        b_addr       = cell_addr(i_reg, j_reg);
        w_addr       = cell_addr(i_reg, j_reg);
        w_data       = '{valid: 1'b1, hop: ik_hop_reg, length: sum_sat};
        w_en         = 1'b0;

        if (cfg_we)
        begin
            vcount_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.operation)
                        OP_LOAD:
                        begin
                            w_addr = cell_addr(src_v, dst_v);
                            if (cmd.no_edge)
                            begin
                                w_data = '0;
                            end
                            else
                            begin
                                w_data = '{valid: 1'b1, hop: dst_v, length: wt_sat};
                            end
                            w_en   = src_ok && dst_ok;
                        end
                        OP_RUN:
                        begin
                            k_next    = '0;
                            i_next    = '0;
                            j_next    = '0;
                            last_next = VB'(n_sat - CW'(1));
                            if (n_sat != '0)
                            begin
                                state_next = S_ROW_RD;
                            end
                        end
                        OP_QUERY:
                        begin
                            qu_next    = src_v;
                            qv_next    = dst_v;
                            cnt_next   = '0;
                            first_next = 1'b1;
                            if (src_ok && dst_ok)
                            begin
                                state_next = S_Q_RD;
                            end
                            else
                            begin
                                rvalid_next = 1'b1;
                                result_next = '{path_vertex: '0, path_distance: '0,
                                                found: 1'b0, last: 1'b1};
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // fetch (i, k) for the row
            S_ROW_RD:
            begin
                a_addr     = cell_addr(i_reg, k_reg);
                state_next = S_ROW_CHK;
            end

            S_ROW_CHK:
            begin
                ik_hop_next  = a_q.hop;
                ik_dist_next = a_q.length;
                j_next       = '0;
                if (a_q.valid)
                begin
                    state_next = S_REL_RD;
                end
                else if (i_reg != last_reg)
                begin
                    i_next     = i_reg + VB'(1);
                    state_next = S_ROW_RD;
                end
                else if (k_reg != last_reg)
                begin
                    i_next     = '0;
                    k_next     = k_reg + VB'(1);
                    state_next = S_ROW_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // fetch (k, j) and (i, j)
            S_REL_RD:
            begin
                a_addr     = cell_addr(k_reg, j_reg);
                b_addr     = cell_addr(i_reg, j_reg);
                state_next = S_REL_WR;
            end

            // relax and write back
            S_REL_WR:
            begin
                w_en = a_q.valid && (!b_q.valid || (b_q.length > sum_sat));
                if (j_reg != last_reg)
                begin
                    j_next     = j_reg + VB'(1);
                    state_next = S_REL_RD;
                end
                else if (i_reg != last_reg)
                begin
                    i_next     = i_reg + VB'(1);
                    state_next = S_ROW_RD;
                end
                else if (k_reg != last_reg)
                begin
                    i_next     = '0;
                    k_next     = k_reg + VB'(1);
                    state_next = S_ROW_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // path walk: fetch (u, v)
            S_Q_RD:
            begin
                a_addr     = cell_addr(qu_reg, qv_reg);
                state_next = S_Q_EMIT;
            end

            S_Q_EMIT:
            begin
                rvalid_next = 1'b1;
                if (first_reg && !a_q.valid)
                begin
                    result_next = '{path_vertex: '0, path_distance: '0,
                                    found: 1'b0, last: 1'b1};
                    state_next  = S_IDLE;
                end
                else
                begin
                    result_next.path_vertex   = pv_x[VERTEX_BITS-1:0];
                    result_next.path_distance = first_reg ? a_q.length : qdist_reg;
                    result_next.found         = 1'b1;
                    result_next.last          = q_done;
                    if (first_reg)
                    begin
                        qdist_next = a_q.length;
                    end
                    first_next = 1'b0;
                    qu_next    = a_q.hop;
                    cnt_next   = cnt_reg + VERTEX_BITS'(1);
                    state_next = q_done ? S_IDLE : S_Q_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign result       = result_reg;
    assign result_valid = rvalid_reg;

endmodule
`default_nettype wire
